/* design/cfb_pkg.sv */
// Package for the CRC-16 frame builder: transfer payload types, frame constants
// and codes shared by the top level and the CRC update unit.
// No dependencies.
`timescale 1ns / 1ps

package cfb_pkg;

    // Input item op codes.
    localparam logic OP_START   = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    // Frame constants.
    localparam logic [7:0]  HDR_BYTE  = 8'hA5;
    localparam logic [7:0]  TAIL_BYTE = 8'h5A;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;

    // Step counter layout: six header bytes, four trailer bytes.
    localparam int STEP_W          = 4;
    localparam logic [STEP_W-1:0] HDR_LAST_STEP  = 4'd5;
    localparam logic [STEP_W-1:0] START_TRL_BASE = 4'd6;
    localparam logic [STEP_W-1:0] START_LAST     = 4'd9;
    localparam logic [STEP_W-1:0] PAY_TRL_BASE   = 4'd1;
    localparam logic [STEP_W-1:0] PAY_LAST       = 4'd4;

    // Trailer byte positions.
    localparam logic [1:0] TRL_CRC_LO = 2'd0;
    localparam logic [1:0] TRL_CRC_HI = 2'd1;
    localparam logic [1:0] TRL_TAIL_0 = 2'd2;
    localparam logic [1:0] TRL_TAIL_1 = 2'd3;

    typedef struct packed {
        logic        op;
        logic [15:0] command_word;
        logic [15:0] payload_len;
        logic [7:0]  payload_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
    } out_item_t;

endpackage

/* design/crc16_frame_builder.sv */
// Top level of the CRC-16 frame builder: item register, byte sequencer,
// running CRC and output register. Depends on cfb_pkg and cfb_crc_byte.
`timescale 1ns / 1ps

// Usage:
// Items enter on the in channel (in_valid/in_ready/in_data). A start item
// opens a frame and yields six header bytes, or ten bytes with the full
// trailer when its payload length is zero. A payload item of an open frame
// yields its byte, plus the four trailer bytes when it is the last one; a
// payload item with no open frame is dropped and yields nothing.
// Frame bytes leave on the out channel (out_valid/out_ready/out_data), one
// per transfer; frame_end marks the last trailer byte.
// An accepted item waits in the item register until the sequencer moves
// its first byte into the output register.
// Throughput: the sequencer emits one byte per cycle while the receiver
// does not stall; an item yields 1, 5, 6 or 10 bytes, a dropped byte none.
// The item register refills in the cycle its last byte moves on, so a run
// of payload bytes streams at one per clock while the receiver keeps up.
// Reset clears the item register, the output register and the frame state;
// the CRC returns to FFFF. When the receiver stalls, the output register
// holds its byte, the sequencer waits, and in_ready falls once the item
// register is occupied.
module crc16_frame_builder
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cfb_pkg::in_item_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output cfb_pkg::out_item_t out_data
);

    logic                       work_valid_reg;
    cfb_pkg::in_item_t          work_reg;
    logic [cfb_pkg::STEP_W-1:0] step_reg;
    logic [cfb_pkg::STEP_W-1:0] step_next;
    logic [15:0]                crc_reg;
    logic [15:0]                crc_next;
    logic [15:0]                bytes_left_reg;
    logic [15:0]                bytes_left_next;
    logic                       frame_open_reg;
    logic                       frame_open_next;
    logic                       out_valid_reg;
    cfb_pkg::out_item_t         out_data_reg;

    logic                       is_start;
    logic                       emit;
    logic                       last;
    logic                       trail;
    logic [cfb_pkg::STEP_W-1:0] step_off;
    logic [1:0]                 trl_idx;
    logic [7:0]                 data_byte;
    cfb_pkg::out_item_t         gen_item;
    logic                       advance;
    logic [15:0]                crc_base;
    logic [15:0]                crc_upd;

    assign is_start = (work_reg.op == cfb_pkg::OP_START);

    // Decode what the current step of the current item emits.
    always_comb
    begin
        emit      = 1'b1;
        last      = 1'b0;
        trail     = 1'b0;
        step_off  = '0;
        data_byte = work_reg.payload_byte;
        if (is_start)
        begin
            if (step_reg <= cfb_pkg::HDR_LAST_STEP)
            begin
                case (step_reg)
                    4'd0, 4'd1: data_byte = cfb_pkg::HDR_BYTE;
                    4'd2:       data_byte = work_reg.command_word[15:8];
                    4'd3:       data_byte = work_reg.command_word[7:0];
                    4'd4:       data_byte = work_reg.payload_len[7:0];
                    default:    data_byte = work_reg.payload_len[15:8];
                endcase
                last = (step_reg == cfb_pkg::HDR_LAST_STEP) && (work_reg.payload_len != 16'd0);
            end
            else
            begin
                trail    = 1'b1;
                step_off = step_reg - cfb_pkg::START_TRL_BASE;
                last     = (step_reg == cfb_pkg::START_LAST);
            end
        end
        else if (!frame_open_reg)
        begin
            // Payload byte with no open frame: dropped.
            emit = 1'b0;
            last = 1'b1;
        end
        else if (step_reg == '0)
        begin
            last = (bytes_left_reg != 16'd1);
        end
        else
        begin
            trail    = 1'b1;
            step_off = step_reg - cfb_pkg::PAY_TRL_BASE;
            last     = (step_reg == cfb_pkg::PAY_LAST);
        end
    end

    assign trl_idx = step_off[1:0];

    // Select the outgoing byte: data or trailer.
    always_comb
    begin
        gen_item.frame_end = 1'b0;
        gen_item.out_byte  = data_byte;
        if (trail)
        begin
            case (trl_idx)
                cfb_pkg::TRL_CRC_LO: gen_item.out_byte = crc_reg[7:0];
                cfb_pkg::TRL_CRC_HI: gen_item.out_byte = crc_reg[15:8];
                cfb_pkg::TRL_TAIL_0: gen_item.out_byte = cfb_pkg::TAIL_BYTE;
                default:
                begin
                    gen_item.out_byte  = cfb_pkg::TAIL_BYTE;
                    gen_item.frame_end = 1'b1;
                end
            endcase
        end
    end

    // The sequencer moves when the output register can take a byte, or for a dropped byte.
    assign advance  = work_valid_reg && (!emit || !out_valid_reg || out_ready);
    assign in_ready = !work_valid_reg || (advance && last);

    // A new frame restarts the CRC from its initial value.
    assign crc_base = (is_start && step_reg == '0) ? cfb_pkg::CRC_INIT : crc_reg;

    cfb_crc_byte u_crc
    (
        .crc_in  (crc_base),
        .data    (data_byte),
        .crc_out (crc_upd)
    );

    // Next frame state.
    always_comb
    begin
        step_next       = step_reg;
        crc_next        = crc_reg;
        bytes_left_next = bytes_left_reg;
        frame_open_next = frame_open_reg;
        if (advance)
        begin
            step_next = last ? '0 : step_reg + 4'd1;
            if (emit && !trail)
            begin
                crc_next = crc_upd;
            end
            if (is_start && step_reg == cfb_pkg::HDR_LAST_STEP)
            begin
                bytes_left_next = work_reg.payload_len;
                frame_open_next = (work_reg.payload_len != 16'd0);
            end
            if (!is_start && emit && !trail)
            begin
                bytes_left_next = bytes_left_reg - 16'd1;
            end
            if (trail && trl_idx == cfb_pkg::TRL_TAIL_1)
            begin
                crc_next        = cfb_pkg::CRC_INIT;
                bytes_left_next = '0;
                frame_open_next = 1'b0;
            end
        end
    end

    // Control and frame state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
            step_reg       <= '0;
            crc_reg        <= cfb_pkg::CRC_INIT;
            bytes_left_reg <= '0;
            frame_open_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            step_reg       <= step_next;
            crc_reg        <= crc_next;
            bytes_left_reg <= bytes_left_next;
            frame_open_reg <= frame_open_next;
            if (in_valid && in_ready)
            begin
                work_valid_reg <= 1'b1;
            end
            else if (advance && last)
            begin
                work_valid_reg <= 1'b0;
            end
            if (advance && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            work_reg <= in_data;
        end
        if (advance && emit)
        begin
            out_data_reg <= gen_item;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef ASSERT_OFF
    // The step counter never runs past the last trailer byte.
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= cfb_pkg::START_LAST)
        else $error("step counter out of range");

    // Between items, an open frame always expects at least one more payload byte.
    a_open_count: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_open_reg && (step_reg == '0)) |-> (bytes_left_reg != 16'd0))
        else $error("open frame with no bytes left");

    // An empty item register leaves the sequencer at its first step.
    a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
        !work_valid_reg |-> (step_reg == '0))
        else $error("sequencer mid-item without an item");

    // The frame end byte is followed by a fresh CRC.
    a_end_crc: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && trail && trl_idx == cfb_pkg::TRL_TAIL_1)
            |=> (crc_reg == cfb_pkg::CRC_INIT) && !frame_open_reg)
        else $error("frame state not cleared after trailer");
`endif

endmodule

/* design/cfb_crc_byte.sv */
// CRC-16/MODBUS update for one byte, all eight bit steps unrolled.
// Depends on cfb_pkg for the polynomial.
`timescale 1ns / 1ps

module cfb_crc_byte
(
    input  logic [15:0] crc_in,
    input  logic [7:0]  data,
    output logic [15:0] crc_out
);

    // Reflected shift register, one bit per step, LSB first.
    always_comb
    begin
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ cfb_pkg::CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

/* tb/sv/crc16_frame_builder_tb.sv */
// Self-checking testbench for crc16_frame_builder: directed frames from a table, then
// random frames; each byte checked against typed bytes or a CRC-16/MODBUS frame predictor.
// Depends on cfb_pkg and the crc16_frame_builder RTL.
`timescale 1ns / 1ps

module crc16_frame_builder_tb;

    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 230;
    localparam int IDLE_PERCENT  = 19;
    localparam int PREDICTED     = -1;

    // One row of the directed table. typed_n < 0 means the predictor supplies the bytes;
    // otherwise typed_n header bytes are taken from typed_hdr, first byte in the top bits.
    typedef struct {
        cfb_pkg::in_item_t item;
        int                typed_n;
        logic [47:0]       typed_hdr;
    } dir_row_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    cfb_pkg::in_item_t  in_data   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    cfb_pkg::out_item_t out_data;

    // Predictor state: running CRC, payload bytes still owed, and whether a frame is open.
    logic [15:0]        crc_model  = cfb_pkg::CRC_INIT;
    logic [15:0]        left_model = '0;
    logic               open_model = 1'b0;
    cfb_pkg::out_item_t frame_buf [10];
    int                 frame_n;

    cfb_pkg::out_item_t frame_bytes_q [$];
    dir_row_t           dir_rows [$];
    cfb_pkg::out_item_t want;

    logic steady       = 1'b0;
    int   errors       = 0;
    int   live_items   = 0;
    int   frames_begun = 0;
    int   strays       = 0;
    int   bytes_seen   = 0;
    int   quiet_cycles = 0;

    crc16_frame_builder dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #1 clk = ~clk;

    // Bitwise CRC-16/MODBUS update over one byte, LSB first.
    function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ cfb_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function void put_frame_byte(input logic [7:0] b, input logic last, input logic fold);
        frame_buf[frame_n] = '{out_byte: b, frame_end: last};
        frame_n++;
        if (fold)
        begin
            crc_model = crc16_fold(crc_model, b);
        end
    endfunction

    // CRC low byte, CRC high byte, then the two tail bytes; the frame closes.
    function void put_trailer();
        put_frame_byte(crc_model[7:0], 1'b0, 1'b0);
        put_frame_byte(crc_model[15:8], 1'b0, 1'b0);
        put_frame_byte(cfb_pkg::TAIL_BYTE, 1'b0, 1'b0);
        put_frame_byte(cfb_pkg::TAIL_BYTE, 1'b1, 1'b0);
        crc_model  = cfb_pkg::CRC_INIT;
        left_model = '0;
        open_model = 1'b0;
    endfunction

    // Works out the bytes one accepted item produces and advances the frame state.
    function void predict_frame(input cfb_pkg::in_item_t item);
        frame_n = 0;
        if (item.op == cfb_pkg::OP_START)
        begin
            // A start always restarts the CRC, abandoning any open frame.
            crc_model = cfb_pkg::CRC_INIT;
            put_frame_byte(cfb_pkg::HDR_BYTE, 1'b0, 1'b1);
            put_frame_byte(cfb_pkg::HDR_BYTE, 1'b0, 1'b1);
            put_frame_byte(item.command_word[15:8], 1'b0, 1'b1);
            put_frame_byte(item.command_word[7:0], 1'b0, 1'b1);
            put_frame_byte(item.payload_len[7:0], 1'b0, 1'b1);
            put_frame_byte(item.payload_len[15:8], 1'b0, 1'b1);
            if (item.payload_len == 16'h0000)
            begin
                put_trailer();
            end
            else
            begin
                left_model = item.payload_len;
                open_model = 1'b1;
            end
        end
        else if (open_model)
        begin
            put_frame_byte(item.payload_byte, 1'b0, 1'b1);
            left_model = left_model - 16'd1;
            if (left_model == 16'h0000)
            begin
                put_trailer();
            end
        end
    endfunction

    function void add_row(input logic op, input logic [15:0] cmd, input logic [15:0] len,
                          input logic [7:0] pb, input int n, input logic [47:0] hdr);
        dir_row_t r;
        r.item      = '{op: op, command_word: cmd, payload_len: len, payload_byte: pb};
        r.typed_n   = n;
        r.typed_hdr = hdr;
        dir_rows.push_back(r);
    endfunction

    // Random gaps on the sender side, skipped during the steady stretch.
    task sender_gap();
        if (!steady && ($urandom_range(0, 99) < IDLE_PERCENT))
        begin
            repeat ($urandom_range(1, 3))
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
    endtask

    // Drives one item until its transfer completes, then queues the expected bytes.
    task send_item(input cfb_pkg::in_item_t item, input int typed_n,
                   input logic [47:0] typed_hdr);
        sender_gap();
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        predict_frame(item);
        if (typed_n >= 0)
        begin
            for (int k = 0; k < typed_n; k++)
            begin
                frame_bytes_q.push_back('{out_byte: typed_hdr[47 - 8 * k -: 8], frame_end: 1'b0});
            end
        end
        else
        begin
            for (int k = 0; k < frame_n; k++)
            begin
                frame_bytes_q.push_back(frame_buf[k]);
            end
        end
        if (item.op == cfb_pkg::OP_START)
        begin
            frames_begun++;
        end
        if (frame_n > 0)
        begin
            live_items++;
        end
        else
        begin
            strays++;
        end
    endtask

    // Holds the sender off until every queued byte has come out.
    task wait_for_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (frame_bytes_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Mostly well-formed frames with random content; some abandoned, some stray bytes.
    task run_random_frames(input int target);
        int                base;
        int                pick;
        int                len;
        int                nsend;
        cfb_pkg::in_item_t it;
        base = live_items;
        while (live_items - base < target)
        begin
            steady = ((live_items - base) >= 90) && ((live_items - base) < 150);
            pick   = $urandom_range(0, 99);
            if (pick < 8)
            begin
                len = 0;
            end
            else if (pick < 70)
            begin
                len = $urandom_range(1, 6);
            end
            else if (pick < 88)
            begin
                len = $urandom_range(7, 24);
            end
            else
            begin
                len = $urandom_range(0, 65535);
            end
            nsend = len;
            if (len > 24)
            begin
                nsend = $urandom_range(0, 6);
            end
            else if ((len > 0) && ($urandom_range(0, 99) < 12))
            begin
                nsend = $urandom_range(0, len - 1);
            end

            it.op           = cfb_pkg::OP_START;
            it.command_word = 16'($urandom);
            it.payload_len  = len[15:0];
            it.payload_byte = 8'($urandom);
            send_item(it, PREDICTED, '0);
            for (int k = 0; k < nsend; k++)
            begin
                it.op           = cfb_pkg::OP_PAYLOAD;
                it.command_word = 16'($urandom);
                it.payload_len  = 16'($urandom);
                it.payload_byte = 8'($urandom);
                send_item(it, PREDICTED, '0);
            end

            // Stray bytes: dropped when the frame closed, passed on when it was cut short.
            if ($urandom_range(0, 99) < 10)
            begin
                repeat ($urandom_range(1, 2))
                begin
                    it.op           = cfb_pkg::OP_PAYLOAD;
                    it.command_word = 16'($urandom);
                    it.payload_len  = 16'($urandom);
                    it.payload_byte = 8'($urandom);
                    send_item(it, PREDICTED, '0);
                end
            end
            if ($urandom_range(0, 99) < 4)
            begin
                wait_for_drain();
            end
        end
        steady = 1'b0;
    endtask

    // Receiver readiness, with random stalls outside the steady stretch.
    always @(posedge clk)
    begin
        out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Output checker: every transfer is matched against the oldest expected byte.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (frame_bytes_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected output byte: expected none, actual %h end=%b",
                         $time, out_data.out_byte, out_data.frame_end);
            end
            else
            begin
                want = frame_bytes_q.pop_front();
                bytes_seen++;
                if (out_data.out_byte !== want.out_byte)
                begin
                    errors++;
                    $display("%0t: out_byte mismatch: expected %h, actual %h",
                             $time, want.out_byte, out_data.out_byte);
                end
                if (out_data.frame_end !== want.frame_end)
                begin
                    errors++;
                    $display("%0t: frame_end mismatch: expected %b, actual %b",
                             $time, want.frame_end, out_data.frame_end);
                end
            end
        end
    end

    // Watchdog: too long without any transfer on either channel ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles, %0d bytes still expected",
                         $time, STALL_LIMIT, frame_bytes_q.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        // Directed table. Typed rows: dropped bytes and headers that can be read directly.
        add_row(cfb_pkg::OP_PAYLOAD, 16'hFFFF, 16'hFFFF, 8'hFF, 0, '0);
        add_row(cfb_pkg::OP_PAYLOAD, 16'h0000, 16'h0000, 8'h00, 0, '0);
        add_row(cfb_pkg::OP_START,   16'h0000, 16'h0000, 8'hFF, PREDICTED, '0);
        add_row(cfb_pkg::OP_START,   16'hFFFF, 16'h0000, 8'h00, PREDICTED, '0);
        add_row(cfb_pkg::OP_START,   16'h1234, 16'h0003, 8'h00, 6, 48'hA5A5_1234_0300);
        add_row(cfb_pkg::OP_PAYLOAD, 16'hFFFF, 16'hFFFF, 8'h00, PREDICTED, '0);
        add_row(cfb_pkg::OP_PAYLOAD, 16'h0000, 16'h0000, 8'hFF, PREDICTED, '0);
        add_row(cfb_pkg::OP_PAYLOAD, 16'h0000, 16'h0001, 8'h80, PREDICTED, '0);
        add_row(cfb_pkg::OP_PAYLOAD, 16'h0000, 16'h0000, 8'h55, 0, '0);
        add_row(cfb_pkg::OP_START,   16'hABCD, 16'h0005, 8'hFF, 6, 48'hA5A5_ABCD_0500);
        add_row(cfb_pkg::OP_PAYLOAD, 16'h0000, 16'h0000, 8'h01, PREDICTED, '0);
        add_row(cfb_pkg::OP_PAYLOAD, 16'h0000, 16'h0000, 8'h02, PREDICTED, '0);
        // Start while a frame is open: the open frame is dropped without a trailer.
        add_row(cfb_pkg::OP_START,   16'hFFFF, 16'hFFFF, 8'h00, 6, 48'hA5A5_FFFF_FFFF);
        add_row(cfb_pkg::OP_PAYLOAD, 16'h0000, 16'h0000, 8'hAA, PREDICTED, '0);
        add_row(cfb_pkg::OP_PAYLOAD, 16'h0000, 16'h0000, 8'h55, PREDICTED, '0);
        add_row(cfb_pkg::OP_START,   16'h0001, 16'h0001, 8'h00, 6, 48'hA5A5_0001_0100);
        add_row(cfb_pkg::OP_PAYLOAD, 16'h0000, 16'h0000, 8'h7F, PREDICTED, '0);
        add_row(cfb_pkg::OP_START,   16'h8000, 16'h0100, 8'h00, 6, 48'hA5A5_8000_0001);
        add_row(cfb_pkg::OP_PAYLOAD, 16'h0000, 16'h0000, 8'h3C, PREDICTED, '0);
        // Zero-length start on top of an open frame.
        add_row(cfb_pkg::OP_START,   16'h5A5A, 16'h0000, 8'h00, PREDICTED, '0);
        add_row(cfb_pkg::OP_PAYLOAD, 16'h0000, 16'h0000, 8'h12, 0, '0);
        add_row(cfb_pkg::OP_START,   16'h0000, 16'h0001, 8'h00, 6, 48'hA5A5_0000_0100);
        add_row(cfb_pkg::OP_PAYLOAD, 16'h0000, 16'h0000, 8'h00, PREDICTED, '0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r])
        begin
            send_item(dir_rows[r].item, dir_rows[r].typed_n, dir_rows[r].typed_hdr);
        end

        // The sender waits for every expected byte before the random part.
        wait_for_drain();
        run_random_frames(RANDOM_ITEMS);

        wait_for_drain();
        repeat (12) @(posedge clk);

        $display("Sent %0d items (%0d frame starts, %0d dropped stray bytes).",
                 live_items + strays, frames_begun, strays);
        $display("Checked %0d output bytes; %0d mismatches.", bytes_seen, errors);
        if (errors == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
